### rtl/tmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmd_pkg
// Types, tag tables and helpers shared by the tagged message deframer.
// ----------------------------------------------------------------------------
package tmd_pkg;

	localparam int NUM_TAGS = 13;
	localparam int TAG_W    = 4;
	localparam int TAG_CHARS = 7;
	localparam int NUM_ARGS = 4;
	localparam int SLOT_W   = $clog2(NUM_ARGS);
	localparam int POS_W    = 17;
	localparam int LEN_W    = 32;
	localparam int ARG_W    = 32;
	localparam int MAXLEN_W = 17;

	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 17'd4096;

	// event codes; codes below NUM_TAGS equal the tag index
	localparam logic [3:0] KIND_BYE      = 4'd5;
	localparam logic [3:0] KIND_UNKNOWN  = 4'd13;
	localparam logic [3:0] KIND_OVERSIZE = 4'd14;

	// tag text, left aligned, unused characters zero
	localparam logic [7:0] TAG_TEXT [NUM_TAGS][TAG_CHARS] = '{
		'{8'h53, 8'h79, 8'h6E, 8'h65, 8'h72, 8'h67, 8'h79},
		'{"Q", "I", "N", "F", 8'h00, 8'h00, 8'h00},
		'{"C", "A", "L", "V", 8'h00, 8'h00, 8'h00},
		'{"C", "I", "N", "N", 8'h00, 8'h00, 8'h00},
		'{"C", "O", "U", "T", 8'h00, 8'h00, 8'h00},
		'{"C", "B", "Y", "E", 8'h00, 8'h00, 8'h00},
		'{"D", "M", "M", "V", 8'h00, 8'h00, 8'h00},
		'{"D", "M", "D", "N", 8'h00, 8'h00, 8'h00},
		'{"D", "M", "U", "P", 8'h00, 8'h00, 8'h00},
		'{"D", "K", "D", "N", 8'h00, 8'h00, 8'h00},
		'{"D", "K", "U", "P", 8'h00, 8'h00, 8'h00},
		'{"D", "K", "R", "P", 8'h00, 8'h00, 8'h00},
		'{"D", "C", "L", "P", 8'h00, 8'h00, 8'h00}
	};

	localparam logic [2:0] TAG_LEN [NUM_TAGS] = '{
		3'd7, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
	};

	// argument sizes in bytes, zero for an absent argument
	localparam logic [2:0] TAG_LAYOUT [NUM_TAGS][NUM_ARGS] = '{
		'{3'd2, 3'd2, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd2, 3'd2, 3'd4, 3'd2},
		'{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd2, 3'd2, 3'd0, 3'd0}, '{3'd1, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd0, 3'd0, 3'd0}, '{3'd2, 3'd2, 3'd2, 3'd0},
		'{3'd2, 3'd2, 3'd2, 3'd0}, '{3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd1, 3'd4, 3'd4, 3'd4}
	};

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_DISCARD = 3'b100
	} phase_t;

	// tag matcher status towards the parser
	typedef struct packed {
		logic                hit;
		logic [TAG_W-1:0]    tag;
		logic                end_hit;
		logic [TAG_W-1:0]    end_tag;
		logic [NUM_TAGS-1:0] next_cand;
	} tm_t;

	// one decoded event
	typedef struct packed {
		logic [3:0]                      kind;
		logic [NUM_ARGS-1:0][ARG_W-1:0] args;
		logic [LEN_W-1:0]                len;
	} res_t;

	// where an argument byte lands: slot and byte position within it
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [1:0]        shift;
	} lane_t;

	function automatic lane_t arg_lane(input logic [TAG_W-1:0] tag,
			input logic [POS_W-1:0] r);
		lane_t      l;
		logic [4:0] off;
		logic [4:0] d;
		logic [2:0] sz;
		logic [2:0] sh;
		l   = '0;
		off = '0;
		for (int k = 0; k < NUM_ARGS; k++) begin
			sz = (tag < TAG_W'(NUM_TAGS)) ? TAG_LAYOUT[tag][k] : 3'd0;
			d  = r[4:0] - off;
			sh = sz - 3'd1 - d[2:0];
			if (!l.valid && sz != 3'd0 && r >= {12'd0, off}
					&& r < {12'd0, off + {2'd0, sz}}) begin
				l.valid = 1'b1;
				l.slot  = SLOT_W'(k);
				l.shift = sh[1:0];
			end
			off = off + {2'd0, sz};
		end
		return l;
	endfunction

endpackage

### rtl/tmd_tag_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmd_tag_match
// Parallel compare of one payload byte against all tags; priority picks.
// ----------------------------------------------------------------------------
module tmd_tag_match (
	input  logic [tmd_pkg::NUM_TAGS-1:0] cand,
	input  logic [tmd_pkg::POS_W-1:0]    pos,
	input  logic [tmd_pkg::LEN_W-1:0]    len,
	input  logic [7:0]                   data,
	output tmd_pkg::tm_t                 tm
);
	import tmd_pkg::*;

	logic [NUM_TAGS-1:0] done_vec;
	logic [NUM_TAGS-1:0] next_vec;
	logic [NUM_TAGS-1:0] end_vec;

	// per tag: fully matched so far, still alive after this byte, fits length
	always_comb begin
		for (int i = 0; i < NUM_TAGS; i++) begin
			done_vec[i] = cand[i] && (pos >= {14'd0, TAG_LEN[i]});
			next_vec[i] = cand[i] && !((pos < {14'd0, TAG_LEN[i]})
				&& (TAG_TEXT[i][pos[2:0]] != data));
			end_vec[i]  = next_vec[i] && (len >= {29'd0, TAG_LEN[i]});
		end
	end

	// first match in table order
	always_comb begin
		tm           = '0;
		tm.next_cand = next_vec;
		for (int i = NUM_TAGS - 1; i >= 0; i--) begin
			if (done_vec[i]) begin
				tm.hit = 1'b1;
				tm.tag = TAG_W'(i);
			end
			if (end_vec[i]) begin
				tm.end_hit = 1'b1;
				tm.end_tag = TAG_W'(i);
			end
		end
	end

endmodule

### rtl/tmd_result_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmd_result_buf
// Output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module tmd_result_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tmd_pkg::res_t din,
	input  logic          event_stall,
	output logic          event_valid,
	output tmd_pkg::res_t dout,
	output logic          full
);
	import tmd_pkg::*;

	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;
	logic pop;
	logic to_out;
	logic to_skid;

	assign pop     = out_v_q && !event_stall;
	assign to_out  = push && (!out_v_q || pop);
	assign to_skid = push && out_v_q && !pop;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			out_v_q  <= 1'b1;
			skid_v_q <= to_skid;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_v_q && pop) begin
			out_q <= skid_q;
		end else if (!skid_v_q && to_out) begin
			out_q <= din;
		end
		if (!skid_v_q && to_skid) begin
			skid_q <= din;
		end
	end

	assign event_valid = out_v_q;
	assign dout        = out_q;
	assign full        = skid_v_q;

endmodule

### rtl/tagged_message_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_message_deframer_core
// Length-prefixed tagged message parser, one byte per cycle while the skid entry is free.
// ----------------------------------------------------------------------------
// Input channel: one item per byte (data_byte, restart) with byte_valid and
// byte_stall. Output channel: one decoded event item (event_kind, four args,
// message_length) with event_valid and event_stall. max_packet_length is
// written through cfg_valid/cfg_ready; cfg_ready is always high.
// Each accepted byte is held in an input register, then decoded against the
// parser state; an event is written into the output register, or into the skid
// entry while that register is held, and event_valid is the output register's flag.
// Throughput is one byte per cycle while the skid entry is free, set by the
// combinational tag compare and argument capture.
// A result waits in the output register and one more in a skid entry; the
// input stalls only while the skid entry is occupied.
// Reset clears the parser to the header phase, opens a closed stream and
// loads max_packet_length with 4096. While the receiver stalls, held events
// stay put and bytes keep flowing until the skid entry fills.
// ----------------------------------------------------------------------------
module tagged_message_deframer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	output logic                           byte_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           restart,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tmd_pkg::MAXLEN_W-1:0]   max_packet_length,
	output logic                           event_valid,
	input  logic                           event_stall,
	output logic [3:0]                     event_kind,
	output logic [tmd_pkg::ARG_W-1:0]      arg_first,
	output logic [tmd_pkg::ARG_W-1:0]      arg_second,
	output logic [tmd_pkg::ARG_W-1:0]      arg_third,
	output logic [tmd_pkg::ARG_W-1:0]      arg_fourth,
	output logic [tmd_pkg::LEN_W-1:0]      message_length
);
	import tmd_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;

	// parser state
	phase_t                         phase_q;
	logic [LEN_W-1:0]               shift_q;
	logic [1:0]                     cnt_q;
	logic [LEN_W-1:0]               plen_q;
	logic [POS_W-1:0]               pos_q;
	logic [NUM_TAGS-1:0]            cand_q;
	logic [NUM_ARGS-1:0][ARG_W-1:0] args_q;
	logic                           closed_q;
	logic [MAXLEN_W-1:0]            max_len_q;

	phase_t                         phase_n;
	logic [LEN_W-1:0]               shift_n;
	logic [1:0]                     cnt_n;
	logic [LEN_W-1:0]               plen_n;
	logic [POS_W-1:0]               pos_n;
	logic [NUM_TAGS-1:0]            cand_n;
	logic [NUM_ARGS-1:0][ARG_W-1:0] args_n;
	logic                           closed_n;

	logic                           full;
	logic                           proc;
	logic                           res_push;
	res_t                           res;
	res_t                           dout;
	tm_t                            tm;
	lane_t                          lane;
	logic [POS_W-1:0]               r_off;
	logic [ARG_W-1:0]               byte_ins;
	logic [NUM_ARGS-1:0][ARG_W-1:0] args_cap;
	logic [POS_W:0]                 pos_inc;
	logic                           last;

	assign byte_stall = full;
	assign cfg_ready  = 1'b1;
	assign proc       = valid_s1 && !full;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !full) begin
			byte_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAXLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_packet_length;
		end
	end

	tmd_tag_match u_match (
		.cand (cand_q),
		.pos  (pos_q),
		.len  (plen_q),
		.data (byte_s1),
		.tm   (tm)
	);

	// argument byte placement for the matched tag
	assign r_off    = pos_q - {14'd0, TAG_LEN[tm.tag]};
	assign lane     = arg_lane(tm.tag, r_off);
	assign byte_ins = {24'd0, byte_s1} << {lane.shift, 3'b000};

	always_comb begin
		for (int k = 0; k < NUM_ARGS; k++) begin
			args_cap[k] = args_q[k];
			if (tm.hit && lane.valid && lane.slot == SLOT_W'(k)) begin
				args_cap[k] = args_q[k] | byte_ins;
			end
		end
	end

	assign pos_inc = {1'b0, pos_q} + 18'd1;
	assign last    = {14'd0, pos_inc} >= plen_q;

	// next state and event
	always_comb begin
		phase_n  = phase_q;
		shift_n  = shift_q;
		cnt_n    = cnt_q;
		plen_n   = plen_q;
		pos_n    = pos_q;
		cand_n   = cand_q;
		args_n   = args_q;
		closed_n = closed_q;
		res_push = 1'b0;
		res      = '0;

		if (restart_s1) begin
			closed_n = 1'b0;
			phase_n  = PH_HEADER;
			cnt_n    = '0;
			plen_n   = '0;
			pos_n    = '0;
			cand_n   = '1;
			args_n   = '0;
		end else if (!closed_q) begin
			case (phase_q)
				PH_DISCARD: begin
					plen_n = plen_q - 32'd1;
					if (plen_q == 32'd1) begin
						phase_n = PH_HEADER;
						cnt_n   = '0;
						plen_n  = '0;
						pos_n   = '0;
						cand_n  = '1;
						args_n  = '0;
					end
				end
				PH_PAYLOAD: begin
					args_n = args_cap;
					cand_n = tm.next_cand;
					pos_n  = pos_inc[POS_W-1:0];
					if (last) begin
						res_push = 1'b1;
						res.len  = plen_q;
						if (tm.end_hit) begin
							res.kind = tm.end_tag;
							res.args = args_cap;
							closed_n = (tm.end_tag == KIND_BYE);
						end else begin
							res.kind = KIND_UNKNOWN;
						end
						phase_n = PH_HEADER;
						cnt_n   = '0;
						plen_n  = '0;
						pos_n   = '0;
						cand_n  = '1;
						args_n  = '0;
					end
				end
				default: begin
					shift_n = {shift_q[LEN_W-9:0], byte_s1};
					if (cnt_q != 2'd3) begin
						cnt_n = cnt_q + 2'd1;
					end else begin
						cnt_n  = '0;
						plen_n = '0;
						pos_n  = '0;
						cand_n = '1;
						args_n = '0;
						if (shift_n > {15'd0, max_len_q}) begin
							res_push = 1'b1;
							res.kind = KIND_OVERSIZE;
							res.len  = shift_n;
							plen_n   = shift_n;
							phase_n  = PH_DISCARD;
						end else if (shift_n == '0) begin
							res_push = 1'b1;
							res.kind = KIND_UNKNOWN;
							phase_n  = PH_HEADER;
						end else begin
							plen_n  = shift_n;
							phase_n = PH_PAYLOAD;
							for (int i = 0; i < NUM_TAGS; i++) begin
								cand_n[i] = ({29'd0, TAG_LEN[i]} <= shift_n);
							end
						end
					end
				end
			endcase
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			shift_q  <= '0;
			cnt_q    <= '0;
			plen_q   <= '0;
			pos_q    <= '0;
			cand_q   <= '1;
			args_q   <= '0;
			closed_q <= 1'b0;
		end else if (proc) begin
			phase_q  <= phase_n;
			shift_q  <= shift_n;
			cnt_q    <= cnt_n;
			plen_q   <= plen_n;
			pos_q    <= pos_n;
			cand_q   <= cand_n;
			args_q   <= args_n;
			closed_q <= closed_n;
		end
	end

	tmd_result_buf u_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (proc && res_push),
		.din         (res),
		.event_stall (event_stall),
		.event_valid (event_valid),
		.dout        (dout),
		.full        (full)
	);

	assign event_kind     = dout.kind;
	assign arg_first      = dout.args[0];
	assign arg_second     = dout.args[1];
	assign arg_third      = dout.args[2];
	assign arg_fourth     = dout.args[3];
	assign message_length = dout.len;

	// skid entry only fills behind a held event
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> event_valid)
		else $error("skid entry occupied with empty output register");

	// a closed stream yields nothing until restart
	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && closed_q && !restart_s1) |-> !res_push)
		else $error("event produced while stream closed");

	// past the tag bytes at most one tag survives
	a_cand_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD && pos_q >= 17'd4) |-> $onehot0(cand_q))
		else $error("several tag candidates after four payload bytes");

	// a byte whose item is rejected by a full skid leaves the state alone
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && valid_s1) |=> ($stable(pos_q) && $stable(phase_q)))
		else $error("parser state moved while item held");

endmodule
